>>> design/line_edit_buffer_assert.svh
// Assertion macros used by the line edit buffer checker.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef LINE_EDIT_BUFFER_ASSERT_SVH
`define LINE_EDIT_BUFFER_ASSERT_SVH

// Same-cycle implication, off during reset.
`define LEB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define LEB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also covers reset itself.
`define LEB_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/leb_pkg.sv
// Shared types and key codes for the line edit buffer.
// No dependencies.
package leb_pkg;

    // Action codes returned to the caller.
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_JOIN_PREV = 3'd1,
        ACT_JOIN_NEXT = 3'd2,
        ACT_PREV_LINE = 3'd3,
        ACT_NEXT_LINE = 3'd4,
        ACT_NEW_LINE  = 3'd5
    } t_action;

    // Opcodes of an input transfer.
    localparam logic OP_EDIT = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Key codes with an editing meaning.
    localparam logic [7:0] KEY_CTRL_A = 8'd1;
    localparam logic [7:0] KEY_CTRL_B = 8'd2;
    localparam logic [7:0] KEY_CTRL_D = 8'd4;
    localparam logic [7:0] KEY_CTRL_E = 8'd5;
    localparam logic [7:0] KEY_CTRL_F = 8'd6;
    localparam logic [7:0] KEY_BS     = 8'd8;
    localparam logic [7:0] KEY_LF     = 8'd10;
    localparam logic [7:0] KEY_CR     = 8'd13;
    localparam logic [7:0] KEY_CTRL_N = 8'd14;
    localparam logic [7:0] KEY_CTRL_P = 8'd16;
    localparam logic [7:0] KEY_CTRL_U = 8'd21;
    localparam logic [7:0] KEY_CTRL_W = 8'd23;
    localparam logic [7:0] KEY_DEL    = 8'd127;

    // Key codes that are swallowed.
    localparam logic [7:0] KEY_NUL    = 8'd0;
    localparam logic [7:0] KEY_CTRL_C = 8'd3;
    localparam logic [7:0] KEY_BEL    = 8'd7;
    localparam logic [7:0] KEY_TAB    = 8'd9;
    localparam logic [7:0] KEY_VT     = 8'd11;
    localparam logic [7:0] KEY_FF     = 8'd12;
    localparam logic [7:0] KEY_CTRL_O = 8'd15;
    localparam logic [7:0] KEY_CTRL_Q = 8'd17;
    localparam logic [7:0] KEY_CTRL_R = 8'd18;
    localparam logic [7:0] KEY_CTRL_S = 8'd19;
    localparam logic [7:0] KEY_CTRL_T = 8'd20;
    localparam logic [7:0] KEY_CTRL_V = 8'd22;
    localparam logic [7:0] KEY_CTRL_X = 8'd24;
    localparam logic [7:0] KEY_CTRL_Y = 8'd25;
    localparam logic [7:0] KEY_CTRL_Z = 8'd26;

    typedef enum logic [3:0] {
        KK_IGNORE,
        KK_BACK,
        KK_DEL_FWD,
        KK_LEFT,
        KK_RIGHT,
        KK_NEXT,
        KK_PREV,
        KK_NEWL,
        KK_CLEAR,
        KK_HOME,
        KK_END,
        KK_INSERT
    } t_key_kind;

    function automatic t_key_kind leb_key_kind(input logic [7:0] key);
        t_key_kind kind;
        case (key)
            KEY_NUL, KEY_CTRL_C, KEY_BEL, KEY_TAB, KEY_VT, KEY_FF, KEY_CTRL_O,
            KEY_CTRL_Q, KEY_CTRL_R, KEY_CTRL_S, KEY_CTRL_T, KEY_CTRL_V,
            KEY_CTRL_X, KEY_CTRL_Y, KEY_CTRL_Z: kind = KK_IGNORE;
            KEY_BS, KEY_DEL:                    kind = KK_BACK;
            KEY_CTRL_D:                         kind = KK_DEL_FWD;
            KEY_CTRL_B:                         kind = KK_LEFT;
            KEY_CTRL_F:                         kind = KK_RIGHT;
            KEY_CTRL_N, KEY_CR:                 kind = KK_NEXT;
            KEY_CTRL_P:                         kind = KK_PREV;
            KEY_LF:                             kind = KK_NEWL;
            KEY_CTRL_W, KEY_CTRL_U:             kind = KK_CLEAR;
            KEY_CTRL_A:                         kind = KK_HOME;
            KEY_CTRL_E:                         kind = KK_END;
            default:                            kind = KK_INSERT;
        endcase
        return kind;
    endfunction

endpackage

>>> design/line_edit_buffer.sv
// Line edit buffer top level: one text line in a byte RAM plus cursor and length.
// Depends on leb_pkg.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+---------------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_opcode, i_key_byte, i_read_index
//  out     | from block| o_out_valid / i_out_stall| o_action, o_cursor_pos, o_line_length,
//          |           |                        | o_read_byte, o_full_drop
//
// A key that moves no byte passes through S_DONE, a read through S_READ and S_DONE,
// an insert or delete through S_SHIFT and S_DONE; an edit moves at most
// LINE_MAX - 1 bytes. The shift streams one byte per cycle through the single
// RAM port pair (read one entry, write it one place over on the next cycle).
// Reset clears cursor, length and the handshake state; the RAM is not cleared,
// since only entries below the length are ever read.
// One item is worked on at a time; a finished result sits in the output
// register, so the next item is taken while the previous result is stalled.
module line_edit_buffer
    import leb_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_opcode,
    input  logic [7:0] i_key_byte,
    input  logic [5:0] i_read_index,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_action,
    output logic [6:0] o_cursor_pos,
    output logic [6:0] o_line_length,
    output logic [7:0] o_read_byte,
    output logic       o_full_drop
);

    localparam int AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;  // RAM address
    localparam int CW = $clog2(LINE_MAX + 1);                   // cursor / length

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_READ  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    // Line storage, one write and one registered read per cycle.
    logic [7:0]    mem [LINE_MAX];
    logic [7:0]    r_rd_data;
    logic          w_wr_en;
    logic [AW-1:0] w_wr_addr;
    logic [7:0]    w_wr_data;
    logic [AW-1:0] w_rd_addr;

    // Control state.
    t_state        r_state, n_state;
    logic [CW-1:0] r_cursor, n_cursor;
    logic [CW-1:0] r_length, n_length;

    // Shift sequencer: r_rp is the next entry to read, r_left the reads still
    // to issue, r_pend marks a read whose data lands at r_wa this cycle.
    logic [AW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_left, n_left;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_wa, n_wa;
    logic          r_down, n_down;    // insert moves bytes toward the end
    logic          r_ins, n_ins;      // key byte still to be written
    logic [7:0]    r_key, n_key;
    logic [AW-1:0] r_kaddr, n_kaddr;

    // Result being built.
    logic          r_rd_ok, n_rd_ok;
    t_action       r_act, n_act;
    logic          r_drop, n_drop;
    logic [7:0]    r_byte, n_byte;

    // Output register.
    logic          r_out_valid, n_out_valid;
    t_action       r_out_action;
    logic [6:0]    r_out_cursor;
    logic [6:0]    r_out_length;
    logic [7:0]    r_out_byte;
    logic          r_out_drop;
    logic          w_out_load;

    logic          w_in_xfer;
    t_key_kind     w_kind;
    logic          w_at_start;
    logic          w_at_end;
    logic          w_full;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_kind     = leb_key_kind(i_key_byte);
    assign w_at_start = (r_cursor == '0);
    assign w_at_end   = (r_cursor == r_length);
    assign w_full     = (r_length == CW'(LINE_MAX));

    always_comb begin
        n_state   = r_state;
        n_cursor  = r_cursor;
        n_length  = r_length;
        n_rp      = r_rp;
        n_left    = r_left;
        n_pend    = 1'b0;
        n_wa      = r_wa;
        n_down    = r_down;
        n_ins     = r_ins;
        n_key     = r_key;
        n_kaddr   = r_kaddr;
        n_rd_ok   = r_rd_ok;
        n_act     = r_act;
        n_drop    = r_drop;
        n_byte    = r_byte;
        w_wr_en   = 1'b0;
        w_wr_addr = r_wa;
        w_wr_data = r_rd_data;
        w_rd_addr = r_rp;
        w_out_load = 1'b0;

        case (r_state)
            S_IDLE: begin
                w_rd_addr = AW'(i_read_index);
                if (w_in_xfer) begin
                    n_act  = ACT_NONE;
                    n_drop = 1'b0;
                    n_byte = '0;
                    n_ins  = 1'b0;
                    n_state = S_DONE;
                    if (i_opcode == OP_READ) begin
                        n_rd_ok = (32'(i_read_index) < 32'(r_length));
                        n_state = S_READ;
                    end else begin
                        case (w_kind)
                            KK_BACK: begin
                                if (!w_at_start) begin
                                    // remove the byte at cursor-1
                                    n_cursor = r_cursor - CW'(1);
                                    n_length = r_length - CW'(1);
                                    n_rp     = AW'(r_cursor);
                                    n_left   = r_length - r_cursor;
                                    n_down   = 1'b0;
                                    n_state  = S_SHIFT;
                                end else begin
                                    n_act = ACT_JOIN_PREV;
                                end
                            end
                            KK_DEL_FWD: begin
                                if (!w_at_end) begin
                                    n_length = r_length - CW'(1);
                                    n_rp     = AW'(r_cursor + CW'(1));
                                    n_left   = r_length - r_cursor - CW'(1);
                                    n_down   = 1'b0;
                                    n_state  = S_SHIFT;
                                end else begin
                                    n_act = ACT_JOIN_NEXT;
                                end
                            end
                            KK_LEFT: begin
                                if (!w_at_start) n_cursor = r_cursor - CW'(1);
                                else n_act = ACT_PREV_LINE;
                            end
                            KK_RIGHT: begin
                                if (!w_at_end) n_cursor = r_cursor + CW'(1);
                                else n_act = ACT_NEXT_LINE;
                            end
                            KK_NEXT: n_act = ACT_NEXT_LINE;
                            KK_PREV: n_act = ACT_PREV_LINE;
                            KK_NEWL: n_act = ACT_NEW_LINE;
                            KK_CLEAR: begin
                                n_cursor = '0;
                                n_length = '0;
                            end
                            KK_HOME: n_cursor = '0;
                            KK_END:  n_cursor = r_length;
                            KK_INSERT: begin
                                if (w_full) begin
                                    n_drop = 1'b1;
                                end else begin
                                    // open a gap at the cursor, then drop the key in
                                    n_rp     = AW'(r_length - CW'(1));
                                    n_left   = r_length - r_cursor;
                                    n_down   = 1'b1;
                                    n_ins    = 1'b1;
                                    n_key    = i_key_byte;
                                    n_kaddr  = AW'(r_cursor);
                                    n_cursor = r_cursor + CW'(1);
                                    n_length = r_length + CW'(1);
                                    n_state  = S_SHIFT;
                                end
                            end
                            default: ;  // ignored keys
                        endcase
                    end
                end
            end
            S_READ: begin
                n_byte  = r_rd_ok ? r_rd_data : '0;
                n_state = S_DONE;
            end
            S_SHIFT: begin
                if (r_left != '0) begin
                    n_rp   = r_down ? r_rp - AW'(1) : r_rp + AW'(1);
                    n_left = r_left - CW'(1);
                    n_pend = 1'b1;
                    n_wa   = r_down ? r_rp + AW'(1) : r_rp - AW'(1);
                end
                if (r_pend) begin
                    w_wr_en = 1'b1;
                end else if (r_left == '0) begin
                    // pipeline drained: write the key into the gap, if any
                    if (r_ins) begin
                        w_wr_en   = 1'b1;
                        w_wr_addr = r_kaddr;
                        w_wr_data = r_key;
                    end
                    n_ins   = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (w_out_load) n_out_valid = 1'b1;
        else n_out_valid = r_out_valid && i_out_stall;
    end

    // RAM
    always_ff @(posedge i_clk) begin
        if (w_wr_en) mem[w_wr_addr] <= w_wr_data;
        r_rd_data <= mem[w_rd_addr];
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cursor    <= '0;
            r_length    <= '0;
            r_pend      <= 1'b0;
            r_left      <= '0;
            r_ins       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_length    <= n_length;
            r_pend      <= n_pend;
            r_left      <= n_left;
            r_ins       <= n_ins;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rp    <= n_rp;
        r_wa    <= n_wa;
        r_down  <= n_down;
        r_key   <= n_key;
        r_kaddr <= n_kaddr;
        r_rd_ok <= n_rd_ok;
        r_act   <= n_act;
        r_drop  <= n_drop;
        r_byte  <= n_byte;
        if (w_out_load) begin
            r_out_action <= r_act;
            r_out_cursor <= 7'(r_cursor);
            r_out_length <= 7'(r_length);
            r_out_byte   <= r_byte;
            r_out_drop   <= r_drop;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out_action;
    assign o_cursor_pos  = r_out_cursor;
    assign o_line_length = r_out_length;
    assign o_read_byte   = r_out_byte;
    assign o_full_drop   = r_out_drop;

endmodule

>>> design/leb_check.sv
// Port-level checker for the line edit buffer, bound to the top level.
// Depends on leb_pkg and line_edit_buffer_assert.svh.
`include "line_edit_buffer_assert.svh"

module leb_check
    import leb_pkg::*;
#(
    parameter int LINE_MAX = 64
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [2:0] o_action,
    input logic [6:0] o_cursor_pos,
    input logic [6:0] o_line_length,
    input logic [7:0] o_read_byte,
    input logic       o_full_drop
);

    // result held while the sink stalls
    `LEB_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_action) && $stable(o_cursor_pos) && $stable(o_line_length) && $stable(o_read_byte) && $stable(o_full_drop), "result changed while stalled")

    // cursor never passes the end of the line (counts are exact below 128)
    `LEB_ASSERT_NOW(a_cursor_in_line, o_out_valid, (LINE_MAX > 127) || (o_cursor_pos <= o_line_length), "cursor beyond line length")

    // a dropped insert is a plain edit on a full line with no action and no read data
    `LEB_ASSERT_NOW(a_drop_clean, o_out_valid && o_full_drop, (o_action == ACT_NONE) && (o_read_byte == 8'd0) && (o_line_length == 7'(LINE_MAX)), "bad dropped insert result")

    // reset empties the output register
    `LEB_ASSERT_NEXT_ALWAYS(a_reset_empty, !i_rst_n, !o_out_valid, "output valid after reset")

endmodule

bind line_edit_buffer leb_check #(
    .LINE_MAX(LINE_MAX)
) u_leb_check (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_action      (o_action),
    .o_cursor_pos  (o_cursor_pos),
    .o_line_length (o_line_length),
    .o_read_byte   (o_read_byte),
    .o_full_drop   (o_full_drop)
);

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// Self-checking bench for line_edit_buffer: directed keys, then random typing and editing.
// Depends on leb_pkg and the line_edit_buffer RTL; uses no files or arguments.

module tb_top;
    import leb_pkg::*;

    localparam int LINE_MAX        = 64;
    localparam int RANDOM_ITEMS    = 1900;
    localparam int MOOD_SPAN       = 80;    // items per random mood
    localparam int CALM_FIRST      = 700;   // random items with no idling on either side
    localparam int CALM_LAST       = 999;
    localparam int HOLD_OFF_AT     = 300;   // reports checked before the long output hold
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int IDLE_PERCENT    = 17;

    // One result transfer, field by field.
    typedef struct packed {
        t_action    action;
        logic [6:0] cursor_pos;
        logic [6:0] line_length;
        logic [7:0] read_byte;
        logic       full_drop;
    } t_line_report;

    // Random stimulus flavors.
    typedef enum int {
        MOOD_TYPE,     // mostly inserts of printable or high bytes: fills the line, hits the full case
        MOOD_EDIT,     // cursor moves, deletes, clears, line actions, plus some inserts and reads
        MOOD_NOISE     // any opcode, any byte
    } t_mood;

    // Shadow copy of the line plus the queue of reports still to come out.
    class t_line_tracker;
        logic [7:0]   text [LINE_MAX];
        int           cur;
        int           len;
        t_line_report expected_reports [$];
        int unsigned  checked;
        int unsigned  mismatches;

        function new();
            cur        = 0;
            len        = 0;
            checked    = 0;
            mismatches = 0;
        endfunction

        function void remove_at(input int pos);
            for (int i = pos; i + 1 < len; i++)
                text[i] = text[i + 1];
            len--;
        endfunction

        // Called once per accepted input transfer.
        function void note_transfer(input logic op, input logic [7:0] key,
                                    input logic [5:0] idx);
            t_line_report r;
            r = '0;
            r.action = ACT_NONE;
            if (op == OP_READ) begin
                if (idx < len)
                    r.read_byte = text[idx];
            end else begin
                case (key)
                    KEY_NUL, KEY_CTRL_C, KEY_BEL, KEY_TAB, KEY_VT, KEY_FF, KEY_CTRL_O,
                    KEY_CTRL_Q, KEY_CTRL_R, KEY_CTRL_S, KEY_CTRL_T, KEY_CTRL_V,
                    KEY_CTRL_X, KEY_CTRL_Y, KEY_CTRL_Z: ;
                    KEY_BS, KEY_DEL: begin
                        if (cur > 0) begin
                            cur--;
                            remove_at(cur);
                        end else
                            r.action = ACT_JOIN_PREV;
                    end
                    KEY_CTRL_D: begin
                        if (cur < len)
                            remove_at(cur);
                        else
                            r.action = ACT_JOIN_NEXT;
                    end
                    KEY_CTRL_B: begin
                        if (cur > 0)
                            cur--;
                        else
                            r.action = ACT_PREV_LINE;
                    end
                    KEY_CTRL_F: begin
                        if (cur < len)
                            cur++;
                        else
                            r.action = ACT_NEXT_LINE;
                    end
                    KEY_CTRL_N, KEY_CR: r.action = ACT_NEXT_LINE;
                    KEY_CTRL_P:         r.action = ACT_PREV_LINE;
                    KEY_LF:             r.action = ACT_NEW_LINE;
                    KEY_CTRL_W, KEY_CTRL_U: begin
                        len = 0;
                        cur = 0;
                    end
                    KEY_CTRL_A: cur = 0;
                    KEY_CTRL_E: cur = len;
                    default: begin
                        if (len >= LINE_MAX)
                            r.full_drop = 1'b1;
                        else begin
                            for (int i = len; i > cur; i--)
                                text[i] = text[i - 1];
                            text[cur] = key;
                            len++;
                            cur++;
                        end
                    end
                endcase
            end
            r.cursor_pos  = 7'(cur);
            r.line_length = 7'(len);
            expected_reports.push_back(r);
        endfunction

        // Called once per accepted output transfer.
        function void check_report(input t_line_report got);
            t_line_report want;
            checked++;
            if (expected_reports.size() == 0) begin
                $error("report with nothing expected: action %0d cursor %0d length %0d",
                       got.action, got.cursor_pos, got.line_length);
                mismatches++;
                return;
            end
            want = expected_reports.pop_front();
            if (got.action !== want.action) begin
                $error("action: expected %0d, got %0d", want.action, got.action);
                mismatches++;
            end
            if (got.cursor_pos !== want.cursor_pos) begin
                $error("cursor_pos: expected %0d, got %0d", want.cursor_pos, got.cursor_pos);
                mismatches++;
            end
            if (got.line_length !== want.line_length) begin
                $error("line_length: expected %0d, got %0d",
                       want.line_length, got.line_length);
                mismatches++;
            end
            if (got.read_byte !== want.read_byte) begin
                $error("read_byte: expected %0d, got %0d", want.read_byte, got.read_byte);
                mismatches++;
            end
            if (got.full_drop !== want.full_drop) begin
                $error("full_drop: expected %0d, got %0d", want.full_drop, got.full_drop);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_reports.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic       i_opcode;
    logic [7:0] i_key_byte;
    logic [5:0] i_read_index;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [2:0] o_action;
    logic [6:0] o_cursor_pos;
    logic [6:0] o_line_length;
    logic [7:0] o_read_byte;
    logic       o_full_drop;

    t_line_tracker tracker = new;
    bit            calm = 1'b0;   // both sides stop idling while set

    line_edit_buffer #(
        .LINE_MAX(LINE_MAX)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_opcode     (i_opcode),
        .i_key_byte   (i_key_byte),
        .i_read_index (i_read_index),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_action     (o_action),
        .o_cursor_pos (o_cursor_pos),
        .o_line_length(o_line_length),
        .o_read_byte  (o_read_byte),
        .o_full_drop  (o_full_drop)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Printable or high byte: always lands as an insert.
    function automatic logic [7:0] text_byte();
        if ($urandom_range(1) != 0)
            return 8'($urandom_range(126, 32));
        return 8'($urandom_range(255, 128));
    endfunction

    // Editing keys; 3..6 are the pure cursor moves.
    function automatic logic [7:0] edit_key(input int unsigned sel);
        case (sel)
            0:       return KEY_BS;
            1:       return KEY_DEL;
            2:       return KEY_CTRL_D;
            3:       return KEY_CTRL_A;
            4:       return KEY_CTRL_E;
            5:       return KEY_CTRL_B;
            6:       return KEY_CTRL_F;
            7:       return KEY_CTRL_N;
            8:       return KEY_CR;
            9:       return KEY_CTRL_P;
            10:      return KEY_LF;
            11:      return KEY_CTRL_W;
            default: return KEY_CTRL_U;
        endcase
    endfunction

    // Offer one input transfer. Entered and left at a falling edge; the payload
    // holds until the rising edge that sees stall low.
    task automatic push_item(input logic op, input logic [7:0] key, input logic [5:0] idx);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_opcode     <= op;
        i_key_byte   <= key;
        i_read_index <= idx;
        do
            @(posedge i_clk);
        while (o_in_stall !== 1'b0);
        tracker.note_transfer(op, key, idx);
        @(negedge i_clk);
    endtask

    // Edit transfer with a random, unused index.
    task automatic push_key(input logic [7:0] key);
        push_item(OP_EDIT, key, 6'($urandom_range(63)));
    endtask

    // Read transfer with a random, unused key byte.
    task automatic push_read(input logic [5:0] idx);
        push_item(OP_READ, 8'($urandom_range(255)), idx);
    endtask

    // Result side: sample at the rising edge, outputs are pre-edge values here.
    always @(posedge i_clk) begin : report_monitor
        t_line_report seen;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            seen.action      = t_action'(o_action);
            seen.cursor_pos  = o_cursor_pos;
            seen.line_length = o_line_length;
            seen.read_byte   = o_read_byte;
            seen.full_drop   = o_full_drop;
            tracker.check_report(seen);
        end
    end

    // Receiver: random stalls, plus one long hold so the block backs up into its input.
    initial begin : out_side
        int hold_left;
        bit hold_done;
        hold_left   = 0;
        hold_done   = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (!hold_done && tracker.checked >= HOLD_OFF_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_OFF_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    // Stimulus and end of run.
    initial begin : in_side
        t_mood       mood;
        int unsigned roll;
        logic        op;
        logic [7:0]  key;
        logic [5:0]  idx;

        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_opcode     = OP_EDIT;
        i_key_byte   = KEY_NUL;
        i_read_index = '0;
        mood         = MOOD_TYPE;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty-line edges, every line action, swallowed keys.
        push_read(6'd0);
        push_key(KEY_BS);           // join previous
        push_key(KEY_CTRL_D);       // join next
        push_key(KEY_CTRL_B);       // previous line
        push_key(KEY_CTRL_F);       // next line
        push_key(KEY_CTRL_N);
        push_key(KEY_CR);
        push_key(KEY_CTRL_P);
        push_key(KEY_LF);
        push_key(KEY_NUL);          // null byte, not inserted
        push_key(KEY_TAB);
        push_key(KEY_CTRL_Z);
        // Inserts of high bytes, an unlisted control code and a plain letter.
        push_key(8'd255);
        push_key(8'd128);
        push_key(8'd27);
        push_key(8'd65);
        push_key(KEY_CTRL_A);
        push_key(KEY_CTRL_F);
        push_key(KEY_CTRL_D);       // delete under cursor, mid-line
        push_key(KEY_CTRL_E);
        push_key(KEY_DEL);          // delete before cursor at end
        push_read(6'd0);
        push_read(6'd63);           // beyond length
        push_key(KEY_CTRL_U);
        push_key(8'd32);
        push_key(KEY_CTRL_W);

        // Random: moods in spans, typing-heavy so the line fills and overflows.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % MOOD_SPAN == 0) begin
                roll = $urandom_range(99);
                mood = (roll < 45) ? MOOD_TYPE : (roll < 80) ? MOOD_EDIT : MOOD_NOISE;
            end
            calm = (n >= CALM_FIRST && n <= CALM_LAST);
            roll = $urandom_range(99);
            op   = OP_EDIT;
            key  = 8'($urandom_range(255));
            idx  = 6'($urandom_range(63));
            case (mood)
                MOOD_TYPE: begin
                    if (roll < 80)
                        key = text_byte();
                    else if (roll < 90)
                        op = OP_READ;
                    else
                        key = edit_key($urandom_range(6, 3));
                end
                MOOD_EDIT: begin
                    if (roll < 30)
                        key = text_byte();
                    else if (roll < 45)
                        op = OP_READ;
                    else
                        key = edit_key($urandom_range(12));
                end
                default: op = 1'($urandom_range(1));
            endcase
            push_item(op, key, idx);
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // Drain, then give a longest shift time for anything stray to show up.
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (LINE_MAX + 8) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("line_edit_buffer test passed");
        else
            $display("line_edit_buffer test failed");
        $finish;
    end

    // Hard stop: several times the slowest legal run.
    initial begin : watchdog
        #(64'd20_000_000);
        $display("line_edit_buffer test failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/leb_pkg.sv
design/line_edit_buffer.sv
design/leb_check.sv
bench/tb_top.sv
